[rtl/dvh_pkg.sv]
// shared types, codes and helpers for the dose-volume histogram engine
package dvh_pkg;

  localparam int BIN_ADDR_MAX = 12;

  typedef enum logic [1:0] {
    ACT_VOXEL  = 2'd0,
    ACT_FINISH = 2'd1,
    ACT_READ   = 2'd2,
    ACT_CLEAR  = 2'd3
  } action_t;

  localparam logic [2:0] CFG_DOSE_IN_CGY       = 3'd0;
  localparam logic [2:0] CFG_BIN_SIZE          = 3'd1;
  localparam logic [2:0] CFG_BINS_IN_USE       = 3'd2;
  localparam logic [2:0] CFG_STRUCTURES_IN_USE = 3'd3;
  localparam logic [2:0] CFG_CUMULATIVE_MODE   = 3'd4;
  localparam logic [2:0] CFG_PERCENT_MODE      = 3'd5;

  typedef struct packed {
    action_t            action;
    logic signed [23:0] dose_value;
    logic [31:0]        structure_mask;
    logic [7:0]         read_bin;
    logic [4:0]         read_structure;
  } in_t;

  typedef struct packed {
    logic [23:0] bin_start_dose;
    logic [31:0] value;
  } out_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_BIN_CMP,
    S_BIN_DIV,
    S_VOX,
    S_ACC,
    S_RD_MEM,
    S_RD_MERGE,
    S_RD_CALC,
    S_RD_DIV,
    S_OUT
  } state_t;

  typedef enum logic [2:0] {
    L_NOP,
    L_INC,
    L_ACC,
    L_CLR,
    L_RD
  } lane_op_t;

  typedef struct packed {
    lane_op_t                op;
    logic [BIN_ADDR_MAX-1:0] addr;
    logic                    acc_clr;
  } lane_ctl_t;

  typedef struct packed {
    logic        start;
    logic [31:0] rem_init;
    logic [47:0] dividend;
    logic [5:0]  steps;
    logic [31:0] divisor;
  } div_req_t;

  function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

endpackage

[rtl/dvh_lane.sv]
// one structure lane: bin count bank with clear, increment and running-sum update
module dvh_lane import dvh_pkg::*; #(
  parameter int DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  lane_ctl_t   ctl,
  input  logic        en,
  output logic [31:0] rdata
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [31:0]   mem [DEPTH];
  lane_op_t      p_op;
  logic          p_en;
  logic [AW-1:0] p_addr;
  logic [AW-1:0] addr;
  logic [31:0]   acc;
  logic [31:0]   sum;
  logic [31:0]   inc;

  assign addr = ctl.addr[AW-1:0];
  assign sum  = sat_add32(acc, rdata);
  assign inc  = sat_add32(rdata, 32'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      p_op <= L_NOP;
      p_en <= 1'b0;
    end else begin
      p_op <= ctl.op;
      p_en <= en;
    end
  end

  always_ff @(posedge clk) begin
    p_addr <= addr;
    if (ctl.acc_clr) begin
      acc <= '0;
    end else if (p_en && p_op == L_ACC) begin
      acc <= sum;
    end
  end

  // write-back lands in the cycle after the read that feeds it
  always_ff @(posedge clk) begin
    if (ctl.op == L_CLR && en) begin
      mem[addr] <= '0;
    end else if (p_en && p_op == L_INC) begin
      mem[p_addr] <= inc;
    end else if (p_en && p_op == L_ACC) begin
      mem[p_addr] <= sum;
    end
    if (ctl.op == L_INC || ctl.op == L_ACC || ctl.op == L_RD) begin
      rdata <= mem[addr];
    end
  end

endmodule

[rtl/dvh_merge.sv]
// picks one lane's count and voxel total for a read
module dvh_merge #(
  parameter int NS = 32
) (
  input  logic                 clk,
  input  logic [NS-1:0][31:0]  lane_data,
  input  logic [NS-1:0][31:0]  vox,
  input  logic [4:0]           sel,
  output logic [31:0]          cnt,
  output logic [31:0]          total
);

  localparam int SW = (NS > 1) ? $clog2(NS) : 1;

  logic          hit;
  logic [SW-1:0] idx;

  assign hit = 7'(sel) < 7'(NS);
  assign idx = SW'(sel);

  always_ff @(posedge clk) begin
    cnt   <= hit ? lane_data[idx] : '0;
    total <= hit ? vox[idx] : '0;
  end

endmodule

[rtl/dvh_div.sv]
// restoring divider, one quotient bit per cycle
module dvh_div import dvh_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  div_req_t    req,
  output logic        done,
  output logic [47:0] quot
);

  logic        busy;
  logic [5:0]  left;
  logic [31:0] rem;
  logic [31:0] dvs;
  logic [47:0] sh;
  logic [32:0] trial;
  logic [32:0] diff;
  logic        qbit;

  assign trial = {rem, sh[47]};
  assign diff  = trial - {1'b0, dvs};
  assign qbit  = !diff[32];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      left <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        left <= req.steps;
      end else if (busy) begin
        left <= left - 6'd1;
        if (left == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem  <= req.rem_init;
      sh   <= req.dividend;
      dvs  <= req.divisor;
      quot <= '0;
    end else if (busy) begin
      rem  <= qbit ? diff[31:0] : trial[31:0];
      sh   <= {sh[46:0], 1'b0};
      quot <= {quot[46:0], qbit};
    end
  end

endmodule

[rtl/dose_volume_histogram_engine_unit.sv]
// Dose-volume histogram engine. One lane per structure keeps that structure's bin counts in
// its own bank of MAX_BINS words; all lanes update in parallel. A voxel's bin is found by
// the bit-serial bin divider, which is skipped when the dose falls below bin 0 or beyond
// the top bin. A finish with cumulative mode sweeps the active bins from the top down, one
// bank read-modify-write per bin. A read passes through the memory read, merge and
// calculation states, and in percent mode, for a hit, through a 48-step fraction divide.
// A clear, and the clearing pass after reset, sweep all MAX_BINS rows with in_stall high;
// configuration writes are always taken. The next item is taken while a read result waits
// at the output.
module dose_volume_histogram_engine_unit import dvh_pkg::*; #(
  parameter int MAX_BINS       = 256,
  parameter int MAX_STRUCTURES = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_t         in_word,
  output logic        out_valid,
  input  logic        out_stall,
  output out_t        out_word,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int AW = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
  localparam int MS = MAX_STRUCTURES;

  state_t state, state_next;

  logic        dose_in_cgy;
  logic [15:0] bin_size;
  logic [8:0]  bins_in_use;
  logic [5:0]  structures_in_use;
  logic        cumulative_mode;
  logic        percent_mode;

  logic [12:0]   nb_act;
  logic [6:0]    ns_act;
  logic [15:0]   w_eff;
  logic [AW-1:0] top_a;

  logic                 accept;
  logic signed [26:0]   num;
  logic [31:0]          den;
  logic [31:0]          mask_r;
  logic [7:0]           rb;
  logic [4:0]           rs;
  logic [AW-1:0]        bin;
  logic [AW-1:0]        sweep;
  logic [MS-1:0][31:0]  vox;
  logic [MS-1:0][31:0]  lane_data;
  logic [MS-1:0]        lane_en;
  logic [MS-1:0]        mbit;
  logic [MS-1:0]        active;
  lane_ctl_t            lane_ctl;
  div_req_t             div_req;
  logic                 div_done;
  logic [47:0]          div_quot;
  logic [31:0]          cnt;
  logic [31:0]          total;
  logic [31:0]          res_val;
  logic [23:0]          res_start;

  logic signed [26:0] d_ext;
  logic [26:0]        w_ext;
  logic [47:0]        num48;
  logic [47:0]        den_top;
  logic               over;
  logic               hit;
  logic               out_free;
  logic [AW-1:0]      q_bin;

  assign cfg_ready = 1'b1;
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  always_comb begin
    if (bins_in_use == '0) begin
      nb_act = 13'd1;
    end else if ({4'b0, bins_in_use} > 13'(MAX_BINS)) begin
      nb_act = 13'(MAX_BINS);
    end else begin
      nb_act = {4'b0, bins_in_use};
    end
    if ({1'b0, structures_in_use} > 7'(MS)) begin
      ns_act = 7'(MS);
    end else begin
      ns_act = {1'b0, structures_in_use};
    end
    w_eff = (bin_size == '0) ? 16'd1 : bin_size;
    top_a = AW'(nb_act - 13'd1);
  end

  assign d_ext   = $signed({{3{in_word.dose_value[23]}}, in_word.dose_value});
  assign w_ext   = {11'b0, w_eff};
  assign num48   = {22'b0, num[25:0]};
  assign den_top = {16'b0, den} << AW;
  assign over    = num48 >= den_top;
  assign q_bin   = div_quot[AW-1:0];
  assign hit     = (13'(rb) < nb_act) && (7'(rs) < ns_act) && (total != '0);

  for (genvar s = 0; s < MS; s++) begin : g_lane
    if (s < 32) begin : g_bit
      assign mbit[s] = mask_r[s];
    end else begin : g_nobit
      assign mbit[s] = 1'b0;
    end
    assign active[s] = 7'(s) < ns_act;
    dvh_lane #(.DEPTH(MAX_BINS)) u_lane (
      .clk   (clk),
      .rst   (rst),
      .ctl   (lane_ctl),
      .en    (lane_en[s]),
      .rdata (lane_data[s])
    );
  end

  dvh_merge #(.NS(MS)) u_merge (
    .clk       (clk),
    .lane_data (lane_data),
    .vox       (vox),
    .sel       (rs),
    .cnt       (cnt),
    .total     (total)
  );

  dvh_div u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .done (div_done),
    .quot (div_quot)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (sweep == '0) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          unique case (in_word.action)
            ACT_VOXEL:  state_next = S_BIN_CMP;
            ACT_FINISH: state_next = cumulative_mode ? S_ACC : S_IDLE;
            ACT_READ:   state_next = S_RD_MEM;
            ACT_CLEAR:  state_next = S_CLEAR;
            default:    state_next = S_IDLE;
          endcase
        end
      end
      S_BIN_CMP: begin
        state_next = (num[26] || over) ? S_VOX : S_BIN_DIV;
      end
      S_BIN_DIV: begin
        if (div_done) state_next = S_VOX;
      end
      S_VOX:      state_next = S_IDLE;
      S_ACC: begin
        if (sweep == '0) state_next = S_IDLE;
      end
      S_RD_MEM:   state_next = S_RD_MERGE;
      S_RD_MERGE: state_next = S_RD_CALC;
      S_RD_CALC:  state_next = (hit && percent_mode) ? S_RD_DIV : S_OUT;
      S_RD_DIV: begin
        if (div_done) state_next = S_OUT;
      end
      S_OUT: begin
        if (out_free) state_next = S_IDLE;
      end
      default:    state_next = S_IDLE;
    endcase
  end

  // outputs to lanes and divider
  always_comb begin
    in_stall         = state != S_IDLE;
    lane_ctl.op      = L_NOP;
    lane_ctl.addr    = '0;
    lane_ctl.acc_clr = state == S_IDLE;
    lane_en          = '0;
    div_req.start    = 1'b0;
    div_req.rem_init = 32'(num48 >> AW);
    div_req.dividend = num48 << (48 - AW);
    div_req.steps    = 6'(AW);
    div_req.divisor  = den;
    unique case (state)
      S_CLEAR: begin
        lane_ctl.op   = L_CLR;
        lane_ctl.addr = BIN_ADDR_MAX'(sweep);
        lane_en       = '1;
      end
      S_BIN_CMP: begin
        div_req.start = !num[26] && !over;
      end
      S_VOX: begin
        lane_ctl.op   = L_INC;
        lane_ctl.addr = BIN_ADDR_MAX'(bin);
        lane_en       = mbit & active;
      end
      S_ACC: begin
        lane_ctl.op   = L_ACC;
        lane_ctl.addr = BIN_ADDR_MAX'(sweep);
        lane_en       = active;
      end
      S_RD_MEM: begin
        lane_ctl.op   = L_RD;
        lane_ctl.addr = BIN_ADDR_MAX'(AW'(rb));
      end
      S_RD_CALC: begin
        div_req.start    = hit && percent_mode;
        div_req.rem_init = '0;
        div_req.dividend = {cnt, 16'b0};
        div_req.steps    = 6'd48;
        div_req.divisor  = total;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_CLEAR;
      sweep             <= AW'(MAX_BINS - 1);
      vox               <= '0;
      out_valid         <= 1'b0;
      dose_in_cgy       <= 1'b0;
      bin_size          <= 16'd256;
      bins_in_use       <= 9'd256;
      structures_in_use <= 6'd32;
      cumulative_mode   <= 1'b1;
      percent_mode      <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_DOSE_IN_CGY:       dose_in_cgy       <= cfg_data[0];
          CFG_BIN_SIZE:          bin_size          <= cfg_data;
          CFG_BINS_IN_USE:       bins_in_use       <= cfg_data[8:0];
          CFG_STRUCTURES_IN_USE: structures_in_use <= cfg_data[5:0];
          CFG_CUMULATIVE_MODE:   cumulative_mode   <= cfg_data[0];
          CFG_PERCENT_MODE:      percent_mode      <= cfg_data[0];
          default: begin
          end
        endcase
      end
      if (state == S_CLEAR || state == S_ACC) begin
        sweep <= sweep - AW'(1);
      end else if (accept && in_word.action == ACT_CLEAR) begin
        sweep <= AW'(MAX_BINS - 1);
        vox   <= '0;
      end else if (accept && in_word.action == ACT_FINISH) begin
        sweep <= top_a;
      end
      if (state == S_VOX) begin
        for (int s = 0; s < MS; s++) begin
          if (mbit[s] && active[s]) vox[s] <= sat_add32(vox[s], 32'd1);
        end
      end
      if (state == S_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mask_r <= in_word.structure_mask;
      rb     <= in_word.read_bin;
      rs     <= in_word.read_structure;
      if (dose_in_cgy) begin
        num <= d_ext + 27'(w_ext * 27'd50);
        den <= 32'(w_eff) * 32'd100;
      end else begin
        num <= (d_ext <<< 1) + $signed(w_ext);
        den <= {15'b0, w_eff, 1'b0};
      end
    end
    if (state == S_BIN_CMP) begin
      if (num[26]) bin <= '0;
      else if (over) bin <= top_a;
    end
    if (state == S_BIN_DIV && div_done) begin
      bin <= (q_bin > top_a) ? top_a : q_bin;
    end
    if (state == S_RD_CALC) begin
      res_start <= 24'(rb) * 24'(bin_size);
      res_val   <= hit ? cnt : '0;
    end
    if (state == S_RD_DIV && div_done) begin
      res_val <= (div_quot[47:32] != '0) ? 32'hFFFF_FFFF : div_quot[31:0];
    end
    if (state == S_OUT && out_free) begin
      out_word.bin_start_dose <= res_start;
      out_word.value          <= res_val;
    end
  end

`ifndef SYNTH
  a_reset_clears: assert property (@(posedge clk) rst |=> state == S_CLEAR)
    else $error("clearing pass does not follow reset");
  a_div_done_waited: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_BIN_DIV || state == S_RD_DIV))
    else $error("divider finished with nobody waiting");
  a_acc_in_range: assert property (@(posedge clk) disable iff (rst)
    state == S_ACC |-> 13'(sweep) < nb_act)
    else $error("running-sum sweep beyond active bins");
  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && out_free) |=> out_valid && state == S_IDLE)
    else $error("read result not presented");
`endif

endmodule
